### src/pfp_pkg.sv
`default_nettype none
package pfp_pkg;

  // Coordinate and intermediate widths, all derived from the coordinate width.
  localparam int CW   = 16;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int NW   = PW + 1;
  localparam int MW   = PW;
  localparam int SQ1W = 2 * MW;
  localparam int SQW  = SQ1W + 2;
  localparam int RTW  = SQW / 2;
  localparam int REMW = RTW + 1;

  // Unit normal and offset formats.
  localparam int UFB  = 14;
  localparam int QW   = UFB + 1;
  localparam int OW   = 16;
  localparam int WW   = 24;
  localparam int PRW  = OW + CW;
  localparam int DOTW = PRW + 2;

  // Cycles from an accepted request to its result strobe.
  localparam int LAT  = 1 + 4 + RTW + QW + 2;

  // Request as it leaves the front part: vertex a and the edge vectors b - a and c - a.
  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] az;
    logic signed [DW-1:0] ux;
    logic signed [DW-1:0] uy;
    logic signed [DW-1:0] uz;
    logic signed [DW-1:0] vx;
    logic signed [DW-1:0] vy;
    logic signed [DW-1:0] vz;
  } req_t;

  // Normal in sign and magnitude form, with the first vertex carried along.
  typedef struct packed {
    logic [2:0]          neg;
    logic [2:0][MW-1:0]  mag;
    logic [2:0][CW-1:0]  a;
  } nrm_t;

  // Side data that travels with the division pipeline.
  typedef struct packed {
    logic [2:0]          neg;
    logic                deg;
    logic [2:0][CW-1:0]  a;
  } side_t;

  // Queue status seen by the front part.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage
`default_nettype wire

### src/pfp_front.sv
`default_nettype none
module pfp_front (
  input  logic                        start,
  output logic                        busy,
  input  logic signed [pfp_pkg::CW-1:0] ax,
  input  logic signed [pfp_pkg::CW-1:0] ay,
  input  logic signed [pfp_pkg::CW-1:0] az,
  input  logic signed [pfp_pkg::CW-1:0] bx,
  input  logic signed [pfp_pkg::CW-1:0] by,
  input  logic signed [pfp_pkg::CW-1:0] bz,
  input  logic signed [pfp_pkg::CW-1:0] cx,
  input  logic signed [pfp_pkg::CW-1:0] cy,
  input  logic signed [pfp_pkg::CW-1:0] cz,
  input  pfp_pkg::qstat_t             qstat,
  output logic                        push,
  output pfp_pkg::req_t               req
);
  import pfp_pkg::*;

  // A request is taken whenever the queue has room.
  assign busy = qstat.full;
  assign push = start & ~busy;

  // Form the edge vectors b - a and c - a.
  always_comb begin
    req.ax = ax;
    req.ay = ay;
    req.az = az;
    req.ux = DW'(bx) - DW'(ax);
    req.uy = DW'(by) - DW'(ay);
    req.uz = DW'(bz) - DW'(az);
    req.vx = DW'(cx) - DW'(ax);
    req.vy = DW'(cy) - DW'(ay);
    req.vz = DW'(cz) - DW'(az);
  end

endmodule
`default_nettype wire

### src/pfp_queue.sv
`default_nettype none
module pfp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pfp_pkg::req_t   din,
  input  logic            pop,
  output pfp_pkg::req_t   head,
  output pfp_pkg::qstat_t qstat
);
  import pfp_pkg::*;

  logic [1:0] count;
  req_t       slot0;
  req_t       slot1;
  logic       do_push;
  logic       do_pop;

  assign qstat.full  = (count == 2'd2);
  assign qstat.empty = (count == 2'd0);
  assign head        = slot0;
  assign do_push     = push & ~qstat.full;
  assign do_pop      = pop & ~qstat.empty;

  // Fill count of the two-entry queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // The head always sits in the first slot; the second slot moves up on a pop.
  always_ff @(posedge clk) begin
    if (do_pop) begin
      if (count == 2'd2) begin
        slot0 <= slot1;
        if (do_push) begin
          slot1 <= din;
        end
      end else if (do_push) begin
        slot0 <= din;
      end
    end else if (do_push) begin
      if (count == 2'd0) begin
        slot0 <= din;
      end else begin
        slot1 <= din;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_pop_fills: assert property (@(posedge clk) disable iff (rst)
    (!qstat.empty && !push) |=> (count == $past(count) - 2'd1))
    else $error("queue pop lost");

endmodule
`default_nettype wire

### src/pfp_isqrt.sv
`default_nettype none
module pfp_isqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    vld_in,
  input  logic [pfp_pkg::SQW-1:0] s_in,
  input  pfp_pkg::nrm_t           side_in,
  output logic                    vld_out,
  output logic [pfp_pkg::RTW-1:0] root_out,
  output pfp_pkg::nrm_t           side_out
);
  import pfp_pkg::*;

  logic            vld_q  [RTW];
  logic [REMW-1:0] rem_q  [RTW];
  logic [RTW-1:0]  root_q [RTW];
  logic [SQW-1:0]  sh_q   [RTW];
  nrm_t            side_q [RTW];

  // One result bit per stage, taken from the top pair of the remaining radicand.
  for (genvar k = 0; k < RTW; k++) begin : g_stage
    logic            vld_src;
    logic [REMW-1:0] rem_src;
    logic [RTW-1:0]  root_src;
    logic [SQW-1:0]  sh_src;
    nrm_t            side_src;
    logic [REMW+1:0] cand;
    logic [REMW+1:0] trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign vld_src  = vld_in;
      assign rem_src  = '0;
      assign root_src = '0;
      assign sh_src   = s_in;
      assign side_src = side_in;
    end else begin : g_next
      assign vld_src  = vld_q[k-1];
      assign rem_src  = rem_q[k-1];
      assign root_src = root_q[k-1];
      assign sh_src   = sh_q[k-1];
      assign side_src = side_q[k-1];
    end

    assign cand  = {rem_src, sh_src[SQW-1 -: 2]};
    assign trial = {1'b0, root_src, 2'b01};
    assign ge    = (cand >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[k]  <= ge ? REMW'(cand - trial) : REMW'(cand);
      root_q[k] <= {root_src[RTW-2:0], ge};
      sh_q[k]   <= {sh_src[SQW-3:0], 2'b00};
      side_q[k] <= side_src;
    end
  end

  assign vld_out  = vld_q[RTW-1];
  assign root_out = root_q[RTW-1];
  assign side_out = side_q[RTW-1];

endmodule
`default_nettype wire

### src/pfp_divs.sv
`default_nettype none
module pfp_divs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           vld_in,
  input  logic [pfp_pkg::RTW-1:0]        len_in,
  input  pfp_pkg::nrm_t                  nrm_in,
  output logic                           vld_out,
  output logic [2:0][pfp_pkg::QW-1:0]    q_out,
  output pfp_pkg::side_t                 side_out
);
  import pfp_pkg::*;

  logic                 vld_q  [QW];
  logic [2:0][REMW-1:0] rem_q  [QW];
  logic [2:0][QW-1:0]   quo_q  [QW];
  logic [RTW-1:0]       len_q  [QW];
  side_t                side_q [QW];

  // Three restoring dividers in lockstep, one quotient bit per stage.
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                 vld_src;
    logic [2:0][REMW-1:0] rem_src;
    logic [2:0][QW-1:0]   quo_src;
    logic [RTW-1:0]       len_src;
    side_t                side_src;
    logic [2:0][REMW-1:0] rem_new;
    logic [2:0][QW-1:0]   quo_new;

    if (k == 0) begin : g_first
      assign vld_src       = vld_in;
      assign len_src       = len_in;
      assign quo_src       = '0;
      assign side_src.neg  = nrm_in.neg;
      assign side_src.deg  = (len_in == '0);
      assign side_src.a    = nrm_in.a;
      for (genvar c = 0; c < 3; c++) begin : g_init
        assign rem_src[c] = REMW'(nrm_in.mag[c]);
      end
    end else begin : g_next
      assign vld_src  = vld_q[k-1];
      assign len_src  = len_q[k-1];
      assign quo_src  = quo_q[k-1];
      assign side_src = side_q[k-1];
      for (genvar c = 0; c < 3; c++) begin : g_shift
        assign rem_src[c] = {rem_q[k-1][c][REMW-2:0], 1'b0};
      end
    end

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        if (rem_src[c] >= REMW'(len_src)) begin
          rem_new[c] = rem_src[c] - REMW'(len_src);
          quo_new[c] = {quo_src[c][QW-2:0], 1'b1};
        end else begin
          rem_new[c] = rem_src[c];
          quo_new[c] = {quo_src[c][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[k]  <= rem_new;
      quo_q[k]  <= quo_new;
      len_q[k]  <= len_src;
      side_q[k] <= side_src;
    end
  end

  assign vld_out  = vld_q[QW-1];
  assign q_out    = quo_q[QW-1];
  assign side_out = side_q[QW-1];

endmodule
`default_nettype wire

### src/pfp_back.sv
`default_nettype none
module pfp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  input  pfp_pkg::req_t                 in_req,
  output logic                          done,
  output logic signed [pfp_pkg::OW-1:0] normal_x,
  output logic signed [pfp_pkg::OW-1:0] normal_y,
  output logic signed [pfp_pkg::OW-1:0] normal_z,
  output logic signed [pfp_pkg::WW-1:0] offset_w,
  output logic                          degenerate
);
  import pfp_pkg::*;

  logic                 vld1, vld2, vld3, vld4, vld5, vld6, vld7;
  logic [5:0][PW-1:0]   prod1;
  logic [2:0][CW-1:0]   a1;
  logic signed [NW-1:0] n_c [3];
  nrm_t                 nrm_c, nrm2, nrm3, nrm4, nrm5;
  logic [2:0][SQ1W-1:0] sq3;
  logic [SQW-1:0]       s4;
  logic [RTW-1:0]       len5;
  logic [2:0][QW-1:0]   q6;
  side_t                side6;
  logic [2:0][OW-1:0]   qs_c;
  logic [2:0][OW-1:0]   qs7;
  logic [2:0][PRW-1:0]  pr7;
  logic                 deg7;
  logic signed [DOTW-1:0] dot_c;
  logic [DOTW-1:0]      dmag_c;
  logic [DOTW-1:0]      wm_c;
  logic [WW-1:0]        w_c;

  // Valid pipeline for the stages kept in this module.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld7 <= 1'b0;
      done <= 1'b0;
    end else begin
      vld1 <= in_vld;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
      vld7 <= vld6;
      done <= vld7;
    end
  end

  // Cross product terms.
  always_ff @(posedge clk) begin
    prod1[0] <= PW'(in_req.uy * in_req.vz);
    prod1[1] <= PW'(in_req.uz * in_req.vy);
    prod1[2] <= PW'(in_req.uz * in_req.vx);
    prod1[3] <= PW'(in_req.ux * in_req.vz);
    prod1[4] <= PW'(in_req.ux * in_req.vy);
    prod1[5] <= PW'(in_req.uy * in_req.vx);
    a1[0]    <= in_req.ax;
    a1[1]    <= in_req.ay;
    a1[2]    <= in_req.az;
  end

  // Normal components, split into sign and magnitude.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      n_c[c] = NW'($signed(prod1[2*c])) - NW'($signed(prod1[2*c+1]));
      nrm_c.neg[c] = n_c[c][NW-1];
      nrm_c.mag[c] = n_c[c][NW-1] ? MW'(-n_c[c]) : MW'(n_c[c]);
    end
    nrm_c.a = a1;
  end

  always_ff @(posedge clk) begin
    nrm2 <= nrm_c;
  end

  // Squared magnitudes, then their sum.
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      sq3[c] <= SQ1W'(nrm2.mag[c] * nrm2.mag[c]);
    end
    nrm3 <= nrm2;
  end

  always_ff @(posedge clk) begin
    s4   <= SQW'(sq3[0]) + SQW'(sq3[1]) + SQW'(sq3[2]);
    nrm4 <= nrm3;
  end

  pfp_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .vld_in   (vld4),
    .s_in     (s4),
    .side_in  (nrm4),
    .vld_out  (vld5),
    .root_out (len5),
    .side_out (nrm5)
  );

  pfp_divs u_divs (
    .clk      (clk),
    .rst      (rst),
    .vld_in   (vld5),
    .len_in   (len5),
    .nrm_in   (nrm5),
    .vld_out  (vld6),
    .q_out    (q6),
    .side_out (side6)
  );

  // Restore the signs and multiply by the first vertex.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qs_c[c] = side6.neg[c] ? -OW'(q6[c]) : OW'(q6[c]);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      pr7[c] <= PRW'($signed(qs_c[c]) * $signed(side6.a[c]));
    end
    qs7  <= qs_c;
    deg7 <= side6.deg;
  end

  // Negated dot product, truncation of the magnitude to Q23.0 and saturation.
  always_comb begin
    dot_c  = DOTW'($signed(pr7[0])) + DOTW'($signed(pr7[1])) + DOTW'($signed(pr7[2]));
    dmag_c = dot_c[DOTW-1] ? DOTW'(-dot_c) : DOTW'(dot_c);
    wm_c   = dmag_c >> UFB;
    if (wm_c > (DOTW'(1) << (WW-1))) begin
      wm_c = DOTW'(1) << (WW-1);
    end
    if (dot_c[DOTW-1]) begin
      w_c = (wm_c == (DOTW'(1) << (WW-1))) ? {1'b0, {(WW-1){1'b1}}} : WW'(wm_c);
    end else begin
      w_c = -WW'(wm_c);
    end
  end

  // Result registers; a degenerate triangle gives all zeros.
  always_ff @(posedge clk) begin
    degenerate <= deg7;
    normal_x   <= deg7 ? '0 : $signed(qs7[0]);
    normal_y   <= deg7 ? '0 : $signed(qs7[1]);
    normal_z   <= deg7 ? '0 : $signed(qs7[2]);
    offset_w   <= deg7 ? '0 : $signed(w_c);
  end

endmodule
`default_nettype wire

### src/plane_from_three_points_core.sv
`default_nettype none
// Plane through three points: unit normal in Q1.14 and offset in Q23.0.
// From an accepted request to its done strobe, a request passes through the
// 35-stage square root and the 15-stage dividers.
// Throughput: one request per cycle; busy stays low since the back never stalls.
// Reset (rst, synchronous, active high) empties the queue and clears all valid bits.
// The receiver cannot stall: each result shows for one cycle with done high.
module plane_from_three_points_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [pfp_pkg::CW-1:0] ax,
  input  logic signed [pfp_pkg::CW-1:0] ay,
  input  logic signed [pfp_pkg::CW-1:0] az,
  input  logic signed [pfp_pkg::CW-1:0] bx,
  input  logic signed [pfp_pkg::CW-1:0] by,
  input  logic signed [pfp_pkg::CW-1:0] bz,
  input  logic signed [pfp_pkg::CW-1:0] cx,
  input  logic signed [pfp_pkg::CW-1:0] cy,
  input  logic signed [pfp_pkg::CW-1:0] cz,
  output logic                          done,
  output logic signed [pfp_pkg::OW-1:0] normal_x,
  output logic signed [pfp_pkg::OW-1:0] normal_y,
  output logic signed [pfp_pkg::OW-1:0] normal_z,
  output logic signed [pfp_pkg::WW-1:0] offset_w,
  output logic                          degenerate
);
  import pfp_pkg::*;

  qstat_t qstat;
  logic   push;
  req_t   req;
  req_t   head;
  logic   pop;

  // Front part: accept and form edge vectors.
  pfp_front u_front (
    .start (start),
    .busy  (busy),
    .ax    (ax),
    .ay    (ay),
    .az    (az),
    .bx    (bx),
    .by    (by),
    .bz    (bz),
    .cx    (cx),
    .cy    (cy),
    .cz    (cz),
    .qstat (qstat),
    .push  (push),
    .req   (req)
  );

  // The back pipeline takes the head whenever the queue holds a request.
  assign pop = ~qstat.empty;

  pfp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (req),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  pfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_vld     (pop),
    .in_req     (head),
    .done       (done),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .offset_w   (offset_w),
    .degenerate (degenerate)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(LAT) done)
    else $error("result strobe missing after a request");
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |->
    (normal_x == '0 && normal_y == '0 && normal_z == '0 && offset_w == '0))
    else $error("degenerate result not zero");
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
              normal_y <= 16'sd16384 && normal_y >= -16'sd16384 &&
              normal_z <= 16'sd16384 && normal_z >= -16'sd16384))
    else $error("unit normal component out of range");

endmodule
`default_nettype wire

### tb/sv/tb_plane_from_three_points_core.sv
`timescale 1ns / 1ps
module tb_plane_from_three_points_core;
  import pfp_pkg::*;

  localparam int WDOG_LIMIT = 4000;
  localparam int MAX_SHOWN  = 10;

  typedef struct {
    logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  } tri_t;

  typedef struct {
    logic signed [OW-1:0] nx, ny, nz;
    logic signed [WW-1:0] w;
    logic                 deg;
  } plane_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, degenerate;
  logic signed [CW-1:0] ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0;
  logic signed [CW-1:0] cx = '0, cy = '0, cz = '0;
  logic signed [OW-1:0] normal_x, normal_y, normal_z;
  logic signed [WW-1:0] offset_w;

  tri_t   pending_tris[$];
  plane_t expected_planes[$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  int     burst_left = 0;
  int     gap_left = 0;
  bit     stim_done = 1'b0;
  bit     taken = 1'b0;

  plane_from_three_points_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
    .cx(cx), .cy(cy), .cz(cz),
    .done(done), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .offset_w(offset_w), .degenerate(degenerate)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Integer square root, floor, built one result bit at a time.
  function automatic longint unsigned root_floor(logic [127:0] s);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 62; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= s) r = c;
    end
    return r[63:0];
  endfunction

  // Normal component scaled to Q1.14, truncated toward zero on the magnitude.
  function automatic longint unit_part(longint n, longint unsigned len);
    longint unsigned q;
    q = ((n < 0 ? -n : n) << UFB) / len;
    return n < 0 ? -longint'(q) : longint'(q);
  endfunction

  // Expected plane for one triangle.
  function automatic plane_t plane_of(tri_t t);
    plane_t p;
    longint ux, uy, uz, vx, vy, vz, nx, ny, nz, qx, qy, qz, dot, w;
    longint unsigned len, wm;
    logic [127:0] sq, mx, my, mz;
    ux = t.bx - t.ax; uy = t.by - t.ay; uz = t.bz - t.az;
    vx = t.cx - t.ax; vy = t.cy - t.ay; vz = t.cz - t.az;
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    // Squares are formed at full width, since they can exceed 64 bits.
    mx = 128'(nx < 0 ? -nx : nx);
    my = 128'(ny < 0 ? -ny : ny);
    mz = 128'(nz < 0 ? -nz : nz);
    sq = mx * mx + my * my + mz * mz;
    len = root_floor(sq);
    if (len == 0) begin
      p.nx = '0; p.ny = '0; p.nz = '0; p.w = '0; p.deg = 1'b1;
      return p;
    end
    qx = unit_part(nx, len);
    qy = unit_part(ny, len);
    qz = unit_part(nz, len);
    dot = qx * t.ax + qy * t.ay + qz * t.az;
    wm = (dot < 0 ? -dot : dot) >> UFB;
    if (wm > 64'd8388608) wm = 64'd8388608;
    w = dot < 0 ? longint'(wm) : -longint'(wm);
    if (w > 8388607) w = 8388607;
    if (w < -8388608) w = -8388608;
    p.nx = qx[OW-1:0]; p.ny = qy[OW-1:0]; p.nz = qz[OW-1:0];
    p.w = w[WW-1:0]; p.deg = 1'b0;
    return p;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return CW'($urandom_range(0, 64)) - 16'sd32;
      default: return CW'($urandom());
    endcase
  endfunction

  function automatic tri_t make_tri(logic signed [CW-1:0] v[9]);
    tri_t t;
    t.ax = v[0]; t.ay = v[1]; t.az = v[2];
    t.bx = v[3]; t.by = v[4]; t.bz = v[5];
    t.cx = v[6]; t.cy = v[7]; t.cz = v[8];
    return t;
  endfunction

  // Directed triangles first, then random ones.
  initial begin
    logic signed [CW-1:0] v[9];
    tri_t t;
    int   k;
    pending_tris.push_back(make_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
    pending_tris.push_back(make_tri('{16, 16, 16, 32, 32, 32, 64, 64, 64}));
    pending_tris.push_back(make_tri('{0, 0, 0, 16, 0, 0, 0, 16, 0}));
    pending_tris.push_back(make_tri('{0, 0, 16, 0, 16, 0, 16, 0, 0}));
    pending_tris.push_back(make_tri('{-32768, -32768, -32768, 32767, -32768, -32768,
                                      -32768, 32767, -32768}));
    pending_tris.push_back(make_tri('{32767, 32767, 32767, -32768, 32767, 32767,
                                      32767, -32768, 32767}));
    pending_tris.push_back(make_tri('{-32768, 32767, -32768, 32767, -32768, 32767,
                                      -32768, -32768, 32767}));
    pending_tris.push_back(make_tri('{32767, -32768, 32767, 32767, 32767, -32768,
                                      -32768, 32767, 32767}));
    pending_tris.push_back(make_tri('{5, 5, 5, 5, 5, 5, 100, -7, 3}));
    pending_tris.push_back(make_tri('{-1, -1, -1, 0, 0, 0, 1, 1, 1}));
    pending_tris.push_back(make_tri('{1, 2, 3, 4, 5, 6, 7, 8, 10}));
    pending_tris.push_back(make_tri('{-1, -1, -1, -1, -1, -1, -1, -1, -1}));
    for (k = 0; k < 1750; k++) begin
      foreach (v[i]) v[i] = rand_coord();
      t = make_tri(v);
      // A share of collinear triangles: c placed on the line through a and b.
      if ($urandom_range(0, 9) == 0) begin
        t.cx = t.ax; t.cy = t.ay; t.cz = t.az;
        if ($urandom_range(0, 1)) begin
          t.bx = t.ax + 16'sd3; t.by = t.ay - 16'sd3; t.bz = t.az + 16'sd3;
          t.cx = t.ax - 16'sd6; t.cy = t.ay + 16'sd6; t.cz = t.az - 16'sd6;
        end
      end
      pending_tris.push_back(t);
    end
    stim_done = 1'b1;
  end

  // Driver: bursts and gaps, inputs change on the falling edge.
  // A request is held until the rising edge that takes it.
  always @(negedge clk) begin
    if (!rst) begin
      if (!start || taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_tris.size() > 0) begin
          tri_t t;
          t = pending_tris.pop_front();
          ax <= t.ax; ay <= t.ay; az <= t.az;
          bx <= t.bx; by <= t.by; bz <= t.bz;
          cx <= t.cx; cy <= t.cy; cz <= t.cz;
          start <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: predicts on accepted requests and checks each done strobe.
  always @(posedge clk) begin
    plane_t e;
    taken <= !rst && start && !busy;
    if (!rst) begin
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (start && !busy) begin
        expected_planes.push_back(plane_of('{ax, ay, az, bx, by, bz, cx, cy, cz}));
      end
      if (done) begin
        if (expected_planes.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_SHOWN) $display("Unexpected result at %0t", $time);
        end else begin
          e = expected_planes.pop_front();
          if (normal_x !== e.nx || normal_y !== e.ny || normal_z !== e.nz ||
              offset_w !== e.w || degenerate !== e.deg) begin
            mismatches <= mismatches + 1;
            if (mismatches < MAX_SHOWN)
              $display({"Mismatch: expected n=(%0d,%0d,%0d) w=%0d deg=%0b ",
                        "got n=(%0d,%0d,%0d) w=%0d deg=%0b"},
                       e.nx, e.ny, e.nz, e.w, e.deg,
                       normal_x, normal_y, normal_z, offset_w, degenerate);
          end
        end
      end
    end
  end

  // Reset, then wait for the stimulus to drain and the pipeline to empty.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (!(stim_done && pending_tris.size() == 0 && !start &&
             expected_planes.size() == 0) && idle_cycles < WDOG_LIMIT)
      @(posedge clk);
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("FAILURE");
    end else begin
      repeat (LAT + 10) @(posedge clk);
      if (mismatches == 0 && expected_planes.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
    end
    $finish;
  end

endmodule
